@@ rtl/g2cp_pkg.sv @@
// shared types and constants for the glyph row to column page converter
package g2cp_pkg;

    localparam int PIXEL_BITS = 32;
    localparam int BYTE_W     = 8;
    localparam int WIDTH_W    = 6;
    localparam int COL_W      = 5;
    localparam int PAGE_W     = 3;
    localparam int HEIGHT_W   = 7;
    // wide enough for any glyph height up to the largest supported one
    localparam int HCMP_W     = 9;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // control broadcast to every column cell
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              acc;
        logic [BYTE_W-1:0] mask;
    } cell_ctl_t;

endpackage

@@ rtl/glyph_rows_to_column_pages_unit.sv @@
// top level: row accumulation into a chain of column cells and page read-out
//
// Takes one glyph pixel row per request (pixel 0 at bit 31) and builds the
// column-major page bytes of a monochrome LCD in a chain of column cells, one
// cell per column. A row that does not end a page leaves the unit ready for the
// next row. A row that ends a page (every eighth row, or the glyph's last row)
// is followed by a read-out of one column byte per cycle while the output is not
// stalled, column 0 first, as the cells shift towards the output register; no
// new row is taken until the last column has left the chain. The user must keep
// to this: glyph_height (cfg_write_data) is written only while idle; the block
// itself does not enforce it.
module glyph_rows_to_column_pages_unit #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [g2cp_pkg::HEIGHT_W-1:0]  cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [g2cp_pkg::PIXEL_BITS-1:0] row_pixels,
    input  logic [g2cp_pkg::WIDTH_W-1:0]   glyph_width,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [g2cp_pkg::BYTE_W-1:0]    column_byte,
    output logic [g2cp_pkg::COL_W-1:0]     column_index,
    output logic [g2cp_pkg::PAGE_W-1:0]    page_index,
    output logic                           last_of_page,
    output logic                           glyph_done
);
    import g2cp_pkg::*;

    localparam int NCELL = (MAX_WIDTH < PIXEL_BITS) ? MAX_WIDTH : PIXEL_BITS;
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [WIDTH_W-1:0] WLIMIT = WIDTH_W'(NCELL);
    localparam logic [HCMP_W-1:0]  HMAX   = HCMP_W'(MAX_HEIGHT);

    state_t state_reg, state_next;

    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [WIDTH_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic                glast_reg, glast_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [PAGE_W-1:0]   out_page_reg, out_page_next;
    logic                out_last_reg, out_last_next;
    logic                out_done_reg, out_done_next;

    logic                in_take, slot_free, emit_last;
    logic [WIDTH_W-1:0]  width_clamped;
    logic [HCMP_W-1:0]   height_ext, height_min1, height_eff, row_ext;
    logic                last_row, page_end;
    cell_ctl_t           ctl;

    logic [BYTE_W-1:0]   acc_bytes [NCELL];
    logic [NCELL-1:0]    col_en;

    assign in_stall  = !state_reg[0];
    assign in_take   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign width_clamped = (glyph_width > WLIMIT) ? WLIMIT : glyph_width;

    // effective height: zero reads as one, clamp to the supported maximum
    assign height_ext  = HCMP_W'(height_reg);
    assign height_min1 = (height_ext == '0) ? HCMP_W'(1) : height_ext;
    assign height_eff  = (height_min1 > HMAX) ? HMAX : height_min1;

    assign row_ext  = HCMP_W'(row_reg);
    assign last_row = (row_ext + HCMP_W'(1)) >= height_eff;
    assign page_end = last_row || (row_ext[2:0] == 3'd7);

    assign emit_last = (col_reg + WIDTH_W'(1)) == width_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        width_next     = width_reg;
        col_next       = col_reg;
        page_next      = page_reg;
        glast_next     = glast_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_col_next   = out_col_reg;
        out_page_next  = out_page_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        ctl.clear      = 1'b0;
        ctl.shift      = 1'b0;
        ctl.acc        = 1'b0;
        ctl.mask       = BYTE_W'(1) << row_reg[2:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ctl.acc  = 1'b1;
                    row_next = last_row ? '0 : row_reg + ROW_W'(1);
                    if (page_end)
                    begin
                        if (width_clamped == '0)
                        begin
                            // nothing to send, just drop the page
                            ctl.clear = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                            width_next = width_clamped;
                            col_next   = '0;
                            page_next  = row_ext[5:3];
                            glast_next = last_row;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = acc_bytes[0];
                    out_col_next   = col_reg[COL_W-1:0];
                    out_page_next  = page_reg;
                    out_last_next  = emit_last;
                    out_done_next  = emit_last && glast_reg;
                    col_next       = col_reg + WIDTH_W'(1);
                    if (emit_last)
                    begin
                        ctl.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.shift = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            height_reg    <= HEIGHT_W'(8);
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                height_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg    <= width_next;
        col_reg      <= col_next;
        page_reg     <= page_next;
        glast_reg    <= glast_next;
        out_byte_reg <= out_byte_next;
        out_col_reg  <= out_col_next;
        out_page_reg <= out_page_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    // column chain, read out at cell 0, zeros fed in at the far end
    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        logic [BYTE_W-1:0] next_byte;

        if (j == NCELL - 1)
        begin : g_end
            assign next_byte = '0;
        end
        else
        begin : g_mid
            assign next_byte = acc_bytes[j+1];
        end

        assign col_en[j] = WIDTH_W'(j) < width_clamped;

        g2cp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .pixel     (row_pixels[PIXEL_BITS-1-j]),
            .col_en    (col_en[j]),
            .next_byte (next_byte),
            .acc_byte  (acc_bytes[j])
        );
    end

    assign out_valid    = out_valid_reg;
    assign column_byte  = out_byte_reg;
    assign column_index = out_col_reg;
    assign page_index   = out_page_reg;
    assign last_of_page = out_last_reg;
    assign glyph_done   = out_done_reg;

endmodule

@@ rtl/g2cp_cell.sv @@
// one column cell: holds the page byte of a column and passes it down the chain
module g2cp_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  g2cp_pkg::cell_ctl_t        ctl,
    input  logic                       pixel,
    input  logic                       col_en,
    input  logic [g2cp_pkg::BYTE_W-1:0] next_byte,
    output logic [g2cp_pkg::BYTE_W-1:0] acc_byte
);
    import g2cp_pkg::*;

    logic [BYTE_W-1:0] acc_reg;
    logic [BYTE_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        priority if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.shift)
        begin
            acc_next = next_byte;
        end
        else if (ctl.acc && pixel && col_en)
        begin
            acc_next = acc_reg | ctl.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_byte = acc_reg;

endmodule

@@ rtl/g2cp_checker.sv @@
// port-level checks for the glyph row to column page converter, with bind
module g2cp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_write_en,
    input logic [g2cp_pkg::HEIGHT_W-1:0]  cfg_write_data,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [g2cp_pkg::PIXEL_BITS-1:0] row_pixels,
    input logic [g2cp_pkg::WIDTH_W-1:0]   glyph_width,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [g2cp_pkg::BYTE_W-1:0]    column_byte,
    input logic [g2cp_pkg::COL_W-1:0]     column_index,
    input logic [g2cp_pkg::PAGE_W-1:0]    page_index,
    input logic                           last_of_page,
    input logic                           glyph_done
);
    import g2cp_pkg::*;

    // a held result keeps its byte, column index and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column_byte)
            && $stable(column_index) && $stable(last_of_page))
        else $error("output changed while stalled");

    // glyph end only on the final byte of a page
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && glyph_done |-> last_of_page)
        else $error("glyph_done without last_of_page");

    // no row request is taken while a page is still being read out
    a_no_row_mid_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_page |-> in_stall)
        else $error("row taken during page read-out");

    // read-out runs without gaps, column by column, same page
    a_next_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_page |=>
            out_valid && column_index == $past(column_index) + COL_W'(1)
            && page_index == $past(page_index))
        else $error("page read-out broke its column order");

endmodule

bind glyph_rows_to_column_pages_unit g2cp_checker u_g2cp_checker (.*);

@@ tb/sv/tb.sv @@
// testbench for the glyph row to column page converter
`timescale 1ns / 1ps

module tb;

    import g2cp_pkg::*;

    localparam int MAX_W     = 32;
    localparam int MAX_H     = 64;
    localparam int COL_LIMIT = (MAX_W < PIXEL_BITS) ? MAX_W : PIXEL_BITS;
    localparam int SETTLE    = 6;
    localparam int TAIL      = 20;
    localparam int RAND_ROWS = 102;
    localparam int DIR_N     = 18;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [COL_W-1:0]  col;
        logic [PAGE_W-1:0] page;
        logic              last;
        logic              done;
    } page_byte_t;

    // one row of the directed table; typed rows carry a uniform page read off by hand
    typedef struct packed {
        bit                    has_h;
        logic [HEIGHT_W-1:0]   h;
        logic [PIXEL_BITS-1:0] px;
        logic [WIDTH_W-1:0]    w;
        bit                    typed;
        logic [6:0]            t_n;
        logic [BYTE_W-1:0]     t_byte;
        logic [PAGE_W-1:0]     t_page;
        bit                    t_done;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [HEIGHT_W-1:0]   cfg_write_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIXEL_BITS-1:0] row_pixels;
    logic [WIDTH_W-1:0]    glyph_width;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_W-1:0]     column_byte;
    logic [COL_W-1:0]      column_index;
    logic [PAGE_W-1:0]     page_index;
    logic                  last_of_page;
    logic                  glyph_done;

    glyph_rows_to_column_pages_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .row_pixels     (row_pixels),
        .glyph_width    (glyph_width),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .column_byte    (column_byte),
        .column_index   (column_index),
        .page_index     (page_index),
        .last_of_page   (last_of_page),
        .glyph_done     (glyph_done)
    );

    // predictor state
    logic [BYTE_W-1:0]   col_acc [MAX_W];
    int unsigned         rows_seen;
    logic [HEIGHT_W-1:0] height_reg;
    page_byte_t          page_bytes_due [$];

    int  mismatches;
    int  rows_sent;
    int  bytes_seen;
    int  height_writes;
    int  burst_left;
    int  pending_gap;
    bit  holding;

    dir_row_t dir_tab [DIR_N];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned glyph_rows();
        int unsigned ht;
        ht = int'(height_reg);
        if (ht == 0)
            ht = 1;
        if (ht > MAX_H)
            ht = MAX_H;
        return ht;
    endfunction

    // fold one row into the column bytes and queue the page when it closes
    task automatic fold_row(input logic [PIXEL_BITS-1:0] px, input logic [WIDTH_W-1:0] w,
                            input bit push);
        int unsigned ht;
        int unsigned wc;
        logic [BYTE_W-1:0] m;
        bit last_row;
        bit page_end;
        page_byte_t pb;
        ht = glyph_rows();
        wc = int'(w);
        if (wc > COL_LIMIT)
            wc = COL_LIMIT;
        m = 8'd1 << (rows_seen % 8);
        for (int j = 0; j < wc; j++)
        begin
            if (px[31 - j])
                col_acc[j] = col_acc[j] | m;
        end
        last_row = (rows_seen + 1) >= ht;
        page_end = last_row || ((rows_seen % 8) == 7);
        if (page_end)
        begin
            for (int j = 0; j < wc; j++)
            begin
                pb.value = col_acc[j];
                pb.col   = j[COL_W-1:0];
                pb.page  = PAGE_W'((rows_seen / 8) % 8);
                pb.last  = (j + 1) == wc;
                pb.done  = ((j + 1) == wc) && last_row;
                if (push)
                    page_bytes_due.push_back(pb);
            end
            for (int j = 0; j < MAX_W; j++)
                col_acc[j] = '0;
        end
        rows_seen = last_row ? 0 : rows_seen + 1;
    endtask

    // present one row, wait for the request to be taken, then decide on idling
    task automatic send_row(input logic [PIXEL_BITS-1:0] px, input logic [WIDTH_W-1:0] w,
                            input bit push);
        int r;
        if (pending_gap > 0)
        begin
            repeat (pending_gap) @(posedge clk);
            pending_gap = 0;
        end
        in_valid    <= 1'b1;
        row_pixels  <= px;
        glyph_width <= w;
        do
            @(posedge clk);
        while (in_stall);
        fold_row(px, w, push);
        rows_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
            holding = 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
            holding = 1'b0;
            r = $urandom_range(0, 9);
            if (r < 6)
                pending_gap = $urandom_range(1, 3);
            else if (r < 9)
                pending_gap = $urandom_range(4, 10);
            else
                pending_gap = $urandom_range(20, 40);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // hold off until every queued column byte has come out and the block has settled
    task automatic drain();
        if (holding)
        begin
            in_valid <= 1'b0;
            holding = 1'b0;
        end
        while (page_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        pending_gap = 0;
    endtask

    task automatic write_height(input logic [HEIGHT_W-1:0] h);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= h;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        height_reg = h;
        height_writes++;
    endtask

    // receiver stall pattern: quiet stretches, random stalls and a periodic comb
    initial
    begin : rx_pattern
        int mode;
        int left;
        int tick;
        out_stall <= 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 120);
            end
            left--;
            tick++;
            unique case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= (tick % 9) < 5;
            endcase
        end
    end

    always @(posedge clk)
    begin : column_check
        page_byte_t got;
        page_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{column_byte, column_index, page_index, last_of_page, glyph_done};
            bytes_seen++;
            if (page_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected column byte: byte %h col %0d page %0d last %b done %b",
                             got.value, got.col, got.page, got.last, got.done);
            end
            else
            begin
                want = page_bytes_due.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp byte %h col %0d page %0d last %b done %b, ",
                                  "got byte %h col %0d page %0d last %b done %b"},
                                 want.value, want.col, want.page, want.last, want.done,
                                 got.value, got.col, got.page, got.last, got.done);
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t    d;
        page_byte_t  pb;
        int          rand_rows;
        int          phase;
        int          n_glyphs;
        int unsigned rows;
        int          r;
        logic [WIDTH_W-1:0] w;
        logic [WIDTH_W-1:0] wr;
        logic [HEIGHT_W-1:0] h;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        row_pixels     <= '0;
        glyph_width    <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        for (int j = 0; j < MAX_W; j++)
            col_acc[j] = '0;
        rows_seen     = 0;
        height_reg    = 7'd8;
        mismatches    = 0;
        rows_sent     = 0;
        bytes_seen    = 0;
        height_writes = 0;
        burst_left    = 0;
        pending_gap   = 0;
        holding       = 1'b0;

        // has_h, h, pixels, width, typed, count, byte, page, done
        dir_tab = '{
            '{1'b0, 7'd0,   32'hFFFF_FFFF, 6'd32, 1'b1, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h8000_0001, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'hAAAA_AAAA, 6'd63, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h5555_5555, 6'd33, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h0000_0000, 6'd0,  1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h1234_5678, 6'd17, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'hFFFF_0000, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h0F0F_0F0F, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b1, 7'd1,   32'hFFFF_FFFF, 6'd32, 1'b1, 7'd32, 8'h01, 3'd0, 1'b1},
            '{1'b0, 7'd0,   32'h0000_0000, 6'd63, 1'b1, 7'd32, 8'h00, 3'd0, 1'b1},
            '{1'b0, 7'd0,   32'hFFFF_FFFF, 6'd0,  1'b1, 7'd0,  8'h00, 3'd0, 1'b1},
            '{1'b0, 7'd0,   32'hFFFF_FFFF, 6'd1,  1'b1, 7'd1,  8'h01, 3'd0, 1'b1},
            '{1'b1, 7'd0,   32'hFFFF_FFFF, 6'd40, 1'b1, 7'd32, 8'h01, 3'd0, 1'b1},
            '{1'b1, 7'd10,  32'hFFFF_FFFF, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'h0000_0000, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b0, 7'd0,   32'hFFFF_FFFF, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0},
            '{1'b1, 7'd2,   32'h0000_0000, 6'd32, 1'b1, 7'd32, 8'h05, 3'd0, 1'b1},
            '{1'b1, 7'd127, 32'h8000_0000, 6'd32, 1'b0, 7'd0,  8'h00, 3'd0, 1'b0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            d = dir_tab[i];
            if (d.has_h)
                write_height(d.h);
            send_row(d.px, d.w, !d.typed);
            if (d.typed)
            begin
                for (int j = 0; j < d.t_n; j++)
                begin
                    pb.value = d.t_byte;
                    pb.col   = j[COL_W-1:0];
                    pb.page  = d.t_page;
                    pb.last  = (j + 1) == d.t_n;
                    pb.done  = d.t_done && ((j + 1) == d.t_n);
                    page_bytes_due.push_back(pb);
                end
            end
        end

        // phase 0 finishes the tall glyph begun above, so every page index is reached
        rand_rows = 0;
        phase     = 0;
        while (rand_rows < RAND_ROWS)
        begin
            if (phase > 0)
            begin
                if (phase == 1)
                    h = 7'd0;
                else if ($urandom_range(0, 7) == 0)
                    h = HEIGHT_W'($urandom_range(57, 127));
                else
                    h = HEIGHT_W'($urandom_range(1, 20));
                write_height(h);
            end
            n_glyphs = (phase == 0) ? 1 : $urandom_range(1, 3);
            for (int g = 0; g < n_glyphs; g++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    w = 6'd0;
                else if (r == 1)
                    w = WIDTH_W'($urandom_range(33, 63));
                else if (r == 2)
                    w = 6'd32;
                else
                    w = WIDTH_W'($urandom_range(1, 32));
                rows = (rows_seen >= glyph_rows()) ? 1 : glyph_rows() - rows_seen;
                // now and then a glyph is cut short
                if (phase > 0 && $urandom_range(0, 5) == 0)
                    rows = $urandom_range(1, rows);
                for (int k = 0; k < rows && rand_rows < RAND_ROWS; k++)
                begin
                    wr = ($urandom_range(0, 9) == 0) ? WIDTH_W'($urandom_range(0, 63)) : w;
                    send_row($urandom, wr, 1'b1);
                    rand_rows++;
                end
            end
            phase++;
        end

        drain();
        repeat (TAIL) @(posedge clk);
        $display("covered %0d rows (%0d random) over %0d height settings",
                 rows_sent, rand_rows, height_writes + 1);
        $display("checked %0d column bytes, %0d mismatches", bytes_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
